/* sv/ucwc_pkg.sv */
package ucwc_pkg;

    // Decoder state carried from one byte to the next
    typedef struct packed {
        logic [1:0]  pending;
        logic [20:0] accum;
        logic        failed;
    } t_state;

    localparam int unsigned CodeW = 21;

    // Leading bit patterns of UTF-8 bytes
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    // Whitelisted code point ranges and single code points
    localparam logic [CodeW-1:0] CJK_LO     = 21'h04E00;
    localparam logic [CodeW-1:0] CJK_HI     = 21'h09FFF;
    localparam logic [CodeW-1:0] EXT_A_LO   = 21'h03400;
    localparam logic [CodeW-1:0] EXT_A_HI   = 21'h04DBF;
    localparam logic [CodeW-1:0] EXT_B_LO   = 21'h20000;
    localparam logic [CodeW-1:0] EXT_B_HI   = 21'h2A6DF;
    localparam logic [CodeW-1:0] EXT_CF_LO  = 21'h2A700;
    localparam logic [CodeW-1:0] EXT_CF_HI  = 21'h2EBEF;
    localparam logic [CodeW-1:0] EXT_GH_LO  = 21'h30000;
    localparam logic [CodeW-1:0] EXT_GH_HI  = 21'h323AF;
    localparam logic [CodeW-1:0] COMPAT_LO  = 21'h0F900;
    localparam logic [CodeW-1:0] COMPAT_HI  = 21'h0FAFF;
    localparam logic [CodeW-1:0] COMPS_LO   = 21'h2F800;
    localparam logic [CodeW-1:0] COMPS_HI   = 21'h2FA1F;
    localparam logic [CodeW-1:0] PT_MIDDOT  = 21'h000B7;
    localparam logic [CodeW-1:0] PT_EMDASH  = 21'h02014;
    localparam logic [CodeW-1:0] PT_LPAREN  = 21'h0FF08;
    localparam logic [CodeW-1:0] PT_RPAREN  = 21'h0FF09;
    localparam logic [CodeW-1:0] PT_COLON   = 21'h0FF1A;

endpackage

/* sv/ucwc_if.sv */
interface ucwc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface ucwc_out_if;
    logic valid;
    logic ready;
    logic valid_res;

    modport source (output valid, output valid_res, input ready);
    modport sink   (input valid, input valid_res, output ready);
endinterface

/* sv/ucwc_whitelist.sv */
module ucwc_whitelist (
    input  logic [ucwc_pkg::CodeW-1:0] i_code,
    output logic                       o_hit
);

    logic w_range;
    logic w_point;

    always_comb begin
        w_range = (i_code >= ucwc_pkg::CJK_LO    && i_code <= ucwc_pkg::CJK_HI)    ||
                  (i_code >= ucwc_pkg::EXT_A_LO  && i_code <= ucwc_pkg::EXT_A_HI)  ||
                  (i_code >= ucwc_pkg::EXT_B_LO  && i_code <= ucwc_pkg::EXT_B_HI)  ||
                  (i_code >= ucwc_pkg::EXT_CF_LO && i_code <= ucwc_pkg::EXT_CF_HI) ||
                  (i_code >= ucwc_pkg::EXT_GH_LO && i_code <= ucwc_pkg::EXT_GH_HI) ||
                  (i_code >= ucwc_pkg::COMPAT_LO && i_code <= ucwc_pkg::COMPAT_HI) ||
                  (i_code >= ucwc_pkg::COMPS_LO  && i_code <= ucwc_pkg::COMPS_HI);
        w_point = (i_code == ucwc_pkg::PT_MIDDOT) || (i_code == ucwc_pkg::PT_EMDASH) ||
                  (i_code == ucwc_pkg::PT_LPAREN) || (i_code == ucwc_pkg::PT_RPAREN) ||
                  (i_code == ucwc_pkg::PT_COLON);
        o_hit   = w_range || w_point;
    end

endmodule

/* sv/ucwc_step.sv */
module ucwc_step (
    input  ucwc_pkg::t_state i_state,
    input  logic [7:0]       i_byte,
    output ucwc_pkg::t_state o_state
);

    logic [ucwc_pkg::CodeW-1:0] w_code;
    logic                       w_hit;

    // Code point after appending this continuation byte
    assign w_code = {i_state.accum[ucwc_pkg::CodeW-7:0], i_byte[5:0]};

    ucwc_whitelist u_whitelist (
        .i_code (w_code),
        .o_hit  (w_hit)
    );

    always_comb begin
        o_state = i_state;
        if (i_state.failed) begin
            // swallow everything until the final byte
            o_state = i_state;
        end else if (i_state.pending == 2'd0) begin
            priority if (!i_byte[7]) begin
                o_state.failed = (i_byte < ucwc_pkg::PRINT_LO) ||
                                 (i_byte > ucwc_pkg::PRINT_HI);
            end else if (i_byte[7:5] == ucwc_pkg::LEAD2_TAG) begin
                o_state.pending = 2'd1;
                o_state.accum   = {16'd0, i_byte[4:0]};
            end else if (i_byte[7:4] == ucwc_pkg::LEAD3_TAG) begin
                o_state.pending = 2'd2;
                o_state.accum   = {17'd0, i_byte[3:0]};
            end else if (i_byte[7:3] == ucwc_pkg::LEAD4_TAG) begin
                o_state.pending = 2'd3;
                o_state.accum   = {18'd0, i_byte[2:0]};
            end else begin
                o_state.failed = 1'b1;
            end
        end else if (i_byte[7:6] != ucwc_pkg::CONT_TAG) begin
            o_state.failed = 1'b1;
        end else begin
            o_state.accum   = w_code;
            o_state.pending = i_state.pending - 2'd1;
            o_state.failed  = (i_state.pending == 2'd1) && !w_hit;
        end
    end

endmodule

/* sv/utf8_cjk_whitelist_checker.sv */
// Checks a byte string for UTF-8 text made of printable ASCII and whitelisted CJK
// ideographs and punctuation. One byte is accepted per clock, back to back, with
// last marking the final byte, save a final byte held while a result is unclaimed.
// One result (valid_res) follows each final byte, from the output register. The rate
// is set by the single-byte decode step between the input and decoder state registers.
// Bytes after an error are swallowed; a sequence left open at the final byte fails.
module utf8_cjk_whitelist_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ucwc_in_if.sink           i_in,
    ucwc_out_if.source        o_out
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    ucwc_pkg::t_state r_state;
    ucwc_pkg::t_state n_state;
    ucwc_pkg::t_state w_step;
    logic             r_out_valid;
    logic             r_out_res;
    logic             w_advance;

    // Hold a final byte while the previous result is still unclaimed
    assign w_advance  = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    ucwc_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .o_state (w_step)
    );

    always_comb begin
        n_state = r_state;
        if (w_advance) begin
            n_state = r_in_last ? '0 : w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_out_res <= !w_step.failed && (w_step.pending == 2'd0);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.valid_res = r_out_res;

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_last) |=> (r_state == '0))
        else $error("decoder state not cleared after final byte");

    a_fail_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_last && w_step.failed) |=> (r_out_valid && !r_out_res))
        else $error("failed string reported as passing");

    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_in_last && r_out_valid))
        else $error("input stalled without a pending final byte");

endmodule

/* verif/tb.sv */
module tb;

    localparam int unsigned RandBytes = 1300;
    localparam int unsigned IdlePct   = 27;
    localparam int unsigned CycleCap  = 200000;

    // Whitelist ranges; single points have lo == hi
    localparam logic [11:0][ucwc_pkg::CodeW-1:0] WL_LO = {
        ucwc_pkg::PT_COLON, ucwc_pkg::PT_RPAREN, ucwc_pkg::PT_LPAREN,
        ucwc_pkg::PT_EMDASH, ucwc_pkg::PT_MIDDOT, ucwc_pkg::COMPS_LO,
        ucwc_pkg::COMPAT_LO, ucwc_pkg::EXT_GH_LO, ucwc_pkg::EXT_CF_LO,
        ucwc_pkg::EXT_B_LO, ucwc_pkg::EXT_A_LO, ucwc_pkg::CJK_LO
    };
    localparam logic [11:0][ucwc_pkg::CodeW-1:0] WL_HI = {
        ucwc_pkg::PT_COLON, ucwc_pkg::PT_RPAREN, ucwc_pkg::PT_LPAREN,
        ucwc_pkg::PT_EMDASH, ucwc_pkg::PT_MIDDOT, ucwc_pkg::COMPS_HI,
        ucwc_pkg::COMPAT_HI, ucwc_pkg::EXT_GH_HI, ucwc_pkg::EXT_CF_HI,
        ucwc_pkg::EXT_B_HI, ucwc_pkg::EXT_A_HI, ucwc_pkg::CJK_HI
    };

    typedef enum logic [1:0] {
        WANT_CALC,
        WANT_PASS,
        WANT_FAIL
    } t_want;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
        t_want      want;
    } t_row;

    logic              clk;
    logic              rst_n;
    int unsigned       cycles;
    int unsigned       errs;
    ucwc_pkg::t_state  dec_state;
    logic              verdicts [$];
    logic [7:0]        text [$];
    t_row              plan [$];
    logic              calm;

    ucwc_in_if  in_ch ();
    ucwc_out_if out_ch ();

    utf8_cjk_whitelist_checker u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial clk = 1'b0;
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Both sides run without idling inside this window
    assign calm = (cycles >= 600) && (cycles < 1000);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleCap) begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= IdlePct);
    end

    task automatic flag_mismatch(string what, logic got, logic want);
        $display("mismatch at cycle %0d: %s (got %b, want %b)", cycles, what, got, want);
        errs++;
    endtask

    task automatic add_byte(logic [7:0] b);
        text = {text, b};
    endtask

    task automatic add_row(logic [7:0] b, logic fin, t_want want);
        t_row r;
        r.b    = b;
        r.fin  = fin;
        r.want = want;
        plan   = {plan, r};
    endtask

    function automatic logic is_listed_cp(logic [ucwc_pkg::CodeW-1:0] cp);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 12; k++) begin
            if (cp >= WL_LO[k] && cp <= WL_HI[k]) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic ucwc_pkg::t_state decode_byte(ucwc_pkg::t_state s, logic [7:0] b);
        ucwc_pkg::t_state n;
        n = s;
        if (!s.failed) begin
            if (s.pending == 2'd0) begin
                if (b[7] == 1'b0) begin
                    if (b < ucwc_pkg::PRINT_LO || b > ucwc_pkg::PRINT_HI) n.failed = 1'b1;
                end else if (b[7:5] == ucwc_pkg::LEAD2_TAG) begin
                    n.pending = 2'd1;
                    n.accum   = {16'd0, b[4:0]};
                end else if (b[7:4] == ucwc_pkg::LEAD3_TAG) begin
                    n.pending = 2'd2;
                    n.accum   = {17'd0, b[3:0]};
                end else if (b[7:3] == ucwc_pkg::LEAD4_TAG) begin
                    n.pending = 2'd3;
                    n.accum   = {18'd0, b[2:0]};
                end else begin
                    n.failed = 1'b1;
                end
            end else if (b[7:6] != ucwc_pkg::CONT_TAG) begin
                n.failed = 1'b1;
            end else begin
                n.accum   = {s.accum[14:0], b[5:0]};
                n.pending = s.pending - 2'd1;
                if (n.pending == 2'd0 && !is_listed_cp(n.accum)) n.failed = 1'b1;
            end
        end
        return n;
    endfunction

    task automatic send_byte(logic [7:0] b, logic fin, t_want want);
        logic verdict;
        while (!calm && $urandom_range(99) < IdlePct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last      <= fin;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        dec_state = decode_byte(dec_state, b);
        if (fin) begin
            verdict = !dec_state.failed && (dec_state.pending == 2'd0);
            if (want == WANT_PASS) verdict = 1'b1;
            if (want == WANT_FAIL) verdict = 1'b0;
            verdicts = {verdicts, verdict};
            dec_state = '0;
        end
    endtask

    function automatic int unsigned min_len(logic [ucwc_pkg::CodeW-1:0] cp);
        if (cp <= 21'h007FF) return 2;
        if (cp <= 21'h0FFFF) return 3;
        return 4;
    endfunction

    function automatic logic [ucwc_pkg::CodeW-1:0] pick_listed_cp(logic near_miss);
        int unsigned k;
        logic [ucwc_pkg::CodeW-1:0] lo;
        logic [ucwc_pkg::CodeW-1:0] hi;
        k  = $urandom_range(11);
        lo = WL_LO[k];
        hi = WL_HI[k];
        if (near_miss) return $urandom_range(1) ? lo - 1'b1 : hi + 1'b1;
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return lo + ucwc_pkg::CodeW'($urandom_range(hi - lo));
        endcase
    endfunction

    task automatic append_cp(logic [ucwc_pkg::CodeW-1:0] cp, int unsigned n);
        case (n)
            2: begin
                add_byte({ucwc_pkg::LEAD2_TAG, cp[10:6]});
            end
            3: begin
                add_byte({ucwc_pkg::LEAD3_TAG, cp[15:12]});
                add_byte({ucwc_pkg::CONT_TAG, cp[11:6]});
            end
            default: begin
                add_byte({ucwc_pkg::LEAD4_TAG, cp[20:18]});
                add_byte({ucwc_pkg::CONT_TAG, cp[17:12]});
                add_byte({ucwc_pkg::CONT_TAG, cp[11:6]});
            end
        endcase
        add_byte({ucwc_pkg::CONT_TAG, cp[5:0]});
    endtask

    // Mostly well-formed strings, with sparse faults and some raw noise
    task automatic build_text();
        int unsigned nchars;
        int unsigned n;
        int unsigned start;
        int unsigned sel;
        int unsigned idx;
        logic [ucwc_pkg::CodeW-1:0] cp;
        logic [7:0] tmp;
        logic [1:0] bad;
        text.delete();
        nchars = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(6, 1);
        if ($urandom_range(99) < 10) begin
            repeat (nchars) add_byte(8'($urandom));
        end else begin
            repeat (nchars) begin
                start = text.size();
                sel   = $urandom_range(99);
                if (sel < 30) begin
                    n = 1;
                    add_byte(8'($urandom_range(ucwc_pkg::PRINT_HI, ucwc_pkg::PRINT_LO)));
                end else if (sel < 93) begin
                    cp = pick_listed_cp(sel >= 85);
                    n  = min_len(cp);
                    if (n < 4 && $urandom_range(9) == 0) n++;
                    append_cp(cp, n);
                end else begin
                    n  = $urandom_range(4, 2);
                    cp = ucwc_pkg::CodeW'($urandom);
                    if (n == 2) cp[20:11] = '0;
                    if (n == 3) cp[20:16] = '0;
                    append_cp(cp, n);
                end
                if ($urandom_range(99) < 5) begin
                    case ($urandom_range(3))
                        0: add_byte($urandom_range(1) ? 8'h7F : 8'($urandom_range(31)));
                        1: if (n > 1) begin
                            idx = start + $urandom_range(n - 1, 1);
                            bad = 2'($urandom_range(2));
                            if (bad == ucwc_pkg::CONT_TAG) bad = 2'b11;
                            tmp = text[idx];
                            tmp[7:6] = bad;
                            text[idx] = tmp;
                        end
                        2: add_byte($urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                                      : 8'($urandom_range(8'hFF, 8'hF8)));
                        default: if (n > 1) begin
                            repeat ($urandom_range(n - 1, 1)) void'(text.pop_back());
                        end
                    endcase
                end
            end
        end
    endtask

    always @(posedge clk) begin : chk_out
        logic want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (verdicts.size() == 0) begin
                flag_mismatch("result with none pending", out_ch.valid_res, 1'bx);
            end else begin
                want = verdicts.pop_front();
                if (out_ch.valid_res !== want) begin
                    flag_mismatch("valid_res", out_ch.valid_res, want);
                end
            end
        end
    end

    initial begin : main
        int unsigned sent;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.last      <= 1'b0;
        rst_n           <= 1'b0;
        dec_state       = '0;
        sent            = 0;

        add_row(8'h20, 1'b1, WANT_PASS);   // lowest printable
        add_row(8'h7E, 1'b1, WANT_PASS);   // highest printable
        add_row(8'h1F, 1'b1, WANT_FAIL);
        add_row(8'h00, 1'b1, WANT_FAIL);   // zero byte
        add_row(8'h7F, 1'b1, WANT_FAIL);   // delete control
        add_row(8'hC2, 1'b0, WANT_CALC);   // middle dot
        add_row(8'hB7, 1'b1, WANT_PASS);
        add_row(8'hE4, 1'b0, WANT_CALC);   // first unified ideograph
        add_row(8'hB8, 1'b0, WANT_CALC);
        add_row(8'h80, 1'b1, WANT_PASS);
        add_row(8'hF0, 1'b0, WANT_CALC);   // first of extension B
        add_row(8'hA0, 1'b0, WANT_CALC);
        add_row(8'h80, 1'b0, WANT_CALC);
        add_row(8'h80, 1'b1, WANT_PASS);
        add_row(8'hC3, 1'b0, WANT_CALC);   // Latin letter, not listed
        add_row(8'hA9, 1'b1, WANT_FAIL);
        add_row(8'hE4, 1'b0, WANT_CALC);   // cut short
        add_row(8'hB8, 1'b1, WANT_FAIL);
        add_row(8'h80, 1'b1, WANT_FAIL);   // continuation as lead
        add_row(8'hFF, 1'b0, WANT_CALC);   // swallow after bad lead
        add_row(8'h41, 1'b1, WANT_FAIL);
        add_row(8'hE4, 1'b0, WANT_CALC);   // broken continuation
        add_row(8'h41, 1'b1, WANT_FAIL);
        add_row(8'hE0, 1'b0, WANT_CALC);   // overlong middle dot
        add_row(8'h82, 1'b0, WANT_CALC);
        add_row(8'hB7, 1'b1, WANT_PASS);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) send_byte(plan[i].b, plan[i].fin, plan[i].want);

        while (sent < RandBytes) begin
            build_text();
            foreach (text[i]) send_byte(text[i], i == text.size() - 1, WANT_CALC);
            sent += text.size();
        end
        in_ch.valid <= 1'b0;

        while (verdicts.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errs == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule

/* files.f */
sv/ucwc_pkg.sv
sv/ucwc_if.sv
sv/ucwc_whitelist.sv
sv/ucwc_step.sv
sv/utf8_cjk_whitelist_checker.sv
verif/tb.sv
